[src/mieu_pkg.sv]
// ----------------------------------------------------------------------------
// mieu_pkg: shared types and constants of the integer execute unit
// Opcodes, function codes, sequencer state, result record, address masks and sign bit.
// ----------------------------------------------------------------------------
package mieu_pkg;

  localparam logic [31:0] AddrMask   = 32'h1FFF_FFFF;
  localparam logic [31:0] RegionMask = 32'hF000_0000;
  localparam logic [31:0] Sign32     = 32'h8000_0000;

  localparam logic [5:0] OpSpecial = 6'd0;
  localparam logic [5:0] OpJ       = 6'd2;
  localparam logic [5:0] OpJal     = 6'd3;
  localparam logic [5:0] OpBeq     = 6'd4;
  localparam logic [5:0] OpBne     = 6'd5;
  localparam logic [5:0] OpBlez    = 6'd6;
  localparam logic [5:0] OpBgtz    = 6'd7;
  localparam logic [5:0] OpAddi    = 6'd8;
  localparam logic [5:0] OpAddiu   = 6'd9;
  localparam logic [5:0] OpSlti    = 6'd10;
  localparam logic [5:0] OpSltiu   = 6'd11;
  localparam logic [5:0] OpAndi    = 6'd12;
  localparam logic [5:0] OpOri     = 6'd13;
  localparam logic [5:0] OpXori    = 6'd14;
  localparam logic [5:0] OpLui     = 6'd15;

  localparam logic [5:0] FnSll   = 6'd0;
  localparam logic [5:0] FnSrl   = 6'd2;
  localparam logic [5:0] FnSra   = 6'd3;
  localparam logic [5:0] FnSllv  = 6'd4;
  localparam logic [5:0] FnSrlv  = 6'd6;
  localparam logic [5:0] FnSrav  = 6'd7;
  localparam logic [5:0] FnJr    = 6'd8;
  localparam logic [5:0] FnJalr  = 6'd9;
  localparam logic [5:0] FnMovz  = 6'd10;
  localparam logic [5:0] FnMovn  = 6'd11;
  localparam logic [5:0] FnDsllv = 6'd20;
  localparam logic [5:0] FnDsrlv = 6'd22;
  localparam logic [5:0] FnDsrav = 6'd23;
  localparam logic [5:0] FnMult  = 6'd24;
  localparam logic [5:0] FnMultu = 6'd25;
  localparam logic [5:0] FnDiv   = 6'd26;
  localparam logic [5:0] FnDivu  = 6'd27;
  localparam logic [5:0] FnAdd   = 6'd32;
  localparam logic [5:0] FnAddu  = 6'd33;
  localparam logic [5:0] FnSub   = 6'd34;
  localparam logic [5:0] FnSubu  = 6'd35;
  localparam logic [5:0] FnAnd   = 6'd36;
  localparam logic [5:0] FnOr    = 6'd37;
  localparam logic [5:0] FnXor   = 6'd38;
  localparam logic [5:0] FnNor   = 6'd39;
  localparam logic [5:0] FnSlt   = 6'd42;
  localparam logic [5:0] FnSltu  = 6'd43;
  localparam logic [5:0] FnDadd  = 6'd44;
  localparam logic [5:0] FnDaddu = 6'd45;
  localparam logic [5:0] FnDsub  = 6'd46;
  localparam logic [5:0] FnDsubu = 6'd47;
  localparam logic [5:0] FnDsll  = 6'd56;
  localparam logic [5:0] FnDsrl  = 6'd58;
  localparam logic [5:0] FnDsra  = 6'd59;
  localparam logic [5:0] FnDsll32 = 6'd60;
  localparam logic [5:0] FnDsrl32 = 6'd62;
  localparam logic [5:0] FnDsra32 = 6'd63;

  localparam logic [0:0] RegStartAddress = 1'b0;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StReadA = 6'b000010,
    StReadB = 6'b000100,
    StExec  = 6'b001000,
    StIter  = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  typedef struct packed {
    logic [31:0] executed_address;
    logic [31:0] fetch_address;
    logic        write_valid;
    logic [4:0]  write_register;
    logic [63:0] write_value;
    logic [63:0] hi_value;
    logic [63:0] lo_value;
    logic        overflow_flag;
    logic        unimplemented_flag;
  } result_t;

endpackage

[src/mieu_if.sv]
// ----------------------------------------------------------------------------
// mieu_insn_if / mieu_res_if: valid-ready channels of the execute unit
// Instruction channel and result channel.
// ----------------------------------------------------------------------------
interface mieu_insn_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface mieu_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] executed_address;
  logic [31:0] fetch_address;
  logic        write_valid;
  logic [4:0]  write_register;
  logic [63:0] write_value;
  logic [63:0] hi_value;
  logic [63:0] lo_value;
  logic        overflow_flag;
  logic        unimplemented_flag;
  modport source (output valid, output executed_address, output fetch_address,
                  output write_valid, output write_register, output write_value,
                  output hi_value, output lo_value, output overflow_flag,
                  output unimplemented_flag, input ready);
  modport sink (input valid, input executed_address, input fetch_address,
                input write_valid, input write_register, input write_value,
                input hi_value, input lo_value, input overflow_flag,
                input unimplemented_flag, output ready);
endinterface

[src/mips_integer_execute_unit.sv]
// ----------------------------------------------------------------------------
// mips_integer_execute_unit: multicycle MIPS64 integer execute stage
// Usage: insn (sink) takes one instruction word, fetched from the last
// fetch_address reported on res. res (source) gives one result item per
// instruction: executed and next fetch address, register write, HI/LO and
// the overflow and unimplemented flags. Before the first item the fetch
// address is start_address, written over the APB port (offset 0) while idle.
// Sequence: the single-read-port register file gives rs, then rt (StReadA,
// StReadB); the instruction is executed in StExec and its result is held in
// the output register. MULT/MULTU and DIV/DIVU then run 32 steps (StIter) on
// the shared one-bit-a-step add/subtract unit plus a finishing state (StOut)
// before the result is valid. One item at a time: insn.ready is high only
// while no instruction is in work and the result register is free, so the
// next item is taken only once the result has been taken.
// Reset clears PC to 0, delay slot to 4, HI/LO to 0; the register file is
// cleared through per-entry valid bits. A stalled result holds in the output
// register and blocks the next instruction until taken.
// ----------------------------------------------------------------------------
module mips_integer_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mieu_insn_if.sink   insn,
  mieu_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mieu_pkg::state_e state_q, state_d;

  logic [63:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [63:0] rf_rdata_q;
  logic [4:0]  rf_raddr;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [63:0] rf_wdata;

  logic [31:0] pc_q, dpc_q, start_q;
  logic [63:0] hi_q, lo_q;
  logic [31:0] ins_q;
  logic [63:0] a_q, b_q;
  logic        out_vld_q;
  mieu_pkg::result_t out_q;

  // iterative mul/div state
  logic        is_div_q, neg_q, neg_r_q, special_q;
  logic [5:0]  cnt_q;
  logic [31:0] divs_q;   // multiplicand or divisor magnitude
  logic [63:0] acc_q;    // {hi, lo} working register

  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mieu_pkg::RegStartAddress);
  assign prdata = (paddr[2] == mieu_pkg::RegStartAddress) ? start_q : 32'd0;

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sa;
  assign op = ins_q[31:26];
  assign rs = ins_q[25:21];
  assign rt = ins_q[20:16];
  assign rd = ins_q[15:11];
  assign sa = ins_q[10:6];
  assign fn = ins_q[5:0];

  function automatic logic [63:0] sx32(input logic [31:0] v);
    sx32 = {{32{v[31]}}, v};
  endfunction

  assign insn.ready = (state_q == mieu_pkg::StIdle) && !out_vld_q;

  // rs is read at the accepting edge, rt in the cycle after, in StReadA
  always_comb begin
    rf_raddr = rt;
    if (state_q == mieu_pkg::StIdle) rf_raddr = insn.instruction_word[25:21];
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_rdata_q <= rf_mem[rf_raddr];
  end

  // ---------------- execute -------------------------------------------------
  logic [63:0] imm, zimm, ex_val, sum64, dif64;
  logic [31:0] a32, b32, r32a, r32s, cur, btarget, jtarget, next_dpc;
  logic        ex_we, ex_ovf, ex_unimpl, start_md, md_div, md_signed;
  logic [4:0]  ex_dst;
  logic [5:0]  sh6;

  always_comb begin
    a32 = a_q[31:0];
    b32 = b_q[31:0];
    cur = pc_q;
    imm = {{48{ins_q[15]}}, ins_q[15:0]};
    zimm = {48'd0, ins_q[15:0]};
    btarget = cur + 32'd4 + {imm[29:0], 2'b00};
    jtarget = (cur & mieu_pkg::RegionMask) | {4'd0, ins_q[25:0], 2'b00};
    r32a = a32 + b32;
    r32s = a32 - b32;
    sum64 = a_q + b_q;
    dif64 = a_q - b_q;
    next_dpc = dpc_q + 32'd4;
    ex_we = 1'b0; ex_dst = rd; ex_val = 64'd0; ex_ovf = 1'b0; ex_unimpl = 1'b0;
    start_md = 1'b0; md_div = 1'b0; md_signed = 1'b0;
    sh6 = 6'd0;
    case (op)
      mieu_pkg::OpSpecial: begin
        case (fn)
          mieu_pkg::FnSll:  begin ex_we = 1'b1; ex_val = sx32(b32 << sa); end
          mieu_pkg::FnSrl:  begin ex_we = 1'b1; ex_val = sx32(b32 >> sa); end
          mieu_pkg::FnSra:  begin ex_we = 1'b1; ex_val = sx32($signed(b32) >>> sa); end
          mieu_pkg::FnSllv: begin ex_we = 1'b1; ex_val = sx32(b32 << a32[4:0]); end
          mieu_pkg::FnSrlv: begin ex_we = 1'b1; ex_val = sx32(b32 >> a32[4:0]); end
          mieu_pkg::FnSrav: begin
            ex_we = 1'b1; ex_val = sx32($signed(b32) >>> a32[4:0]);
          end
          mieu_pkg::FnJr:   next_dpc = a32;
          mieu_pkg::FnJalr: begin
            next_dpc = a32; ex_we = 1'b1; ex_val = {32'd0, cur + 32'd8};
          end
          mieu_pkg::FnMovz: begin ex_we = (b_q == 64'd0); ex_val = a_q; end
          mieu_pkg::FnMovn: begin ex_we = (b_q != 64'd0); ex_val = a_q; end
          mieu_pkg::FnDsllv: begin ex_we = 1'b1; ex_val = b_q << a_q[5:0]; end
          mieu_pkg::FnDsrlv: begin ex_we = 1'b1; ex_val = b_q >> a_q[5:0]; end
          mieu_pkg::FnDsrav: begin ex_we = 1'b1; ex_val = $signed(b_q) >>> a_q[5:0]; end
          mieu_pkg::FnMult:  begin start_md = 1'b1; md_signed = 1'b1; end
          mieu_pkg::FnMultu: start_md = 1'b1;
          mieu_pkg::FnDiv:   begin start_md = 1'b1; md_div = 1'b1; md_signed = 1'b1; end
          mieu_pkg::FnDivu:  begin start_md = 1'b1; md_div = 1'b1; end
          mieu_pkg::FnAdd: begin
            if (((a32 ^ r32a) & (b32 ^ r32a) & mieu_pkg::Sign32) != 32'd0) ex_ovf = 1'b1;
            else begin ex_we = 1'b1; ex_val = sx32(r32a); end
          end
          mieu_pkg::FnAddu: begin ex_we = 1'b1; ex_val = sx32(r32a); end
          mieu_pkg::FnSub: begin
            if (((a32 ^ b32) & (a32 ^ r32s) & mieu_pkg::Sign32) != 32'd0) ex_ovf = 1'b1;
            else begin ex_we = 1'b1; ex_val = sx32(r32s); end
          end
          mieu_pkg::FnSubu: begin ex_we = 1'b1; ex_val = sx32(r32s); end
          mieu_pkg::FnAnd: begin ex_we = 1'b1; ex_val = a_q & b_q; end
          mieu_pkg::FnOr:  begin ex_we = 1'b1; ex_val = a_q | b_q; end
          mieu_pkg::FnXor: begin ex_we = 1'b1; ex_val = a_q ^ b_q; end
          mieu_pkg::FnNor: begin ex_we = 1'b1; ex_val = ~(a_q | b_q); end
          mieu_pkg::FnSlt: begin
            ex_we = 1'b1; ex_val = {63'd0, $signed(a_q) < $signed(b_q)};
          end
          mieu_pkg::FnSltu: begin ex_we = 1'b1; ex_val = {63'd0, a_q < b_q}; end
          mieu_pkg::FnDadd: begin
            if (((a_q ^ sum64) & (b_q ^ sum64) & {1'b1, 63'd0}) != 64'd0) ex_ovf = 1'b1;
            else begin ex_we = 1'b1; ex_val = sum64; end
          end
          mieu_pkg::FnDaddu: begin ex_we = 1'b1; ex_val = sum64; end
          mieu_pkg::FnDsub: begin
            if (((a_q ^ b_q) & (a_q ^ dif64) & {1'b1, 63'd0}) != 64'd0) ex_ovf = 1'b1;
            else begin ex_we = 1'b1; ex_val = dif64; end
          end
          mieu_pkg::FnDsubu: begin ex_we = 1'b1; ex_val = dif64; end
          mieu_pkg::FnDsll: begin ex_we = 1'b1; ex_val = b_q << sa; end
          mieu_pkg::FnDsrl: begin ex_we = 1'b1; ex_val = b_q >> sa; end
          mieu_pkg::FnDsra: begin ex_we = 1'b1; ex_val = $signed(b_q) >>> sa; end
          mieu_pkg::FnDsll32: begin
            sh6 = {1'b1, sa}; ex_we = 1'b1; ex_val = b_q << sh6;
          end
          mieu_pkg::FnDsrl32: begin
            sh6 = {1'b1, sa}; ex_we = 1'b1; ex_val = b_q >> sh6;
          end
          mieu_pkg::FnDsra32: begin
            sh6 = {1'b1, sa}; ex_we = 1'b1; ex_val = $signed(b_q) >>> sh6;
          end
          default: ex_unimpl = 1'b1;
        endcase
      end
      mieu_pkg::OpJ:   next_dpc = jtarget;
      mieu_pkg::OpJal: begin
        next_dpc = jtarget; ex_we = 1'b1; ex_dst = 5'd31; ex_val = {32'd0, cur + 32'd8};
      end
      mieu_pkg::OpBeq:  if (a_q == b_q) next_dpc = btarget;
      mieu_pkg::OpBne:  if (a_q != b_q) next_dpc = btarget;
      mieu_pkg::OpBlez: if (!($signed(a_q) > 64'sd0)) next_dpc = btarget;
      mieu_pkg::OpBgtz: if ($signed(a_q) > 64'sd0) next_dpc = btarget;
      mieu_pkg::OpAddi: begin
        ex_dst = rt;
        if (((a32 ^ (a32 + imm[31:0])) & (imm[31:0] ^ (a32 + imm[31:0]))
             & mieu_pkg::Sign32) != 32'd0) ex_ovf = 1'b1;
        else begin ex_we = 1'b1; ex_val = sx32(a32 + imm[31:0]); end
      end
      mieu_pkg::OpAddiu: begin ex_dst = rt; ex_we = 1'b1; ex_val = sx32(a32 + imm[31:0]); end
      mieu_pkg::OpSlti: begin
        ex_dst = rt; ex_we = 1'b1; ex_val = {63'd0, $signed(a_q) < $signed(imm)};
      end
      mieu_pkg::OpSltiu: begin ex_dst = rt; ex_we = 1'b1; ex_val = {63'd0, a_q < imm}; end
      mieu_pkg::OpAndi: begin ex_dst = rt; ex_we = 1'b1; ex_val = a_q & zimm; end
      mieu_pkg::OpOri:  begin ex_dst = rt; ex_we = 1'b1; ex_val = a_q | zimm; end
      mieu_pkg::OpXori: begin ex_dst = rt; ex_we = 1'b1; ex_val = a_q ^ zimm; end
      mieu_pkg::OpLui: begin ex_dst = rt; ex_we = 1'b1; ex_val = sx32({ins_q[15:0], 16'd0}); end
      default: ex_unimpl = 1'b1;
    endcase
    if (ex_dst == 5'd0) ex_we = 1'b0;
  end

  // shared add/subtract step: shift-add multiply or restoring divide
  logic [32:0] step_sum;
  logic [63:0] acc_step;
  always_comb begin
    if (is_div_q) begin
      // shifted partial remainder needs all 33 bits
      step_sum = acc_q[63:31] - {1'b0, divs_q};
      if (!step_sum[32]) acc_step = {step_sum[31:0], acc_q[30:0], 1'b1};
      else               acc_step = {acc_q[62:0], 1'b0};
    end else begin
      step_sum = {1'b0, acc_q[63:32]} + {1'b0, (acc_q[0] ? divs_q : 32'd0)};
      acc_step = {step_sum, acc_q[31:1]};
    end
  end

  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [31:0] q_fix, r_fix;
  assign ma = (md_signed && a32[31]) ? -a32 : a32;
  assign mb = (md_signed && b32[31]) ? -b32 : b32;
  assign prod = neg_q ? -acc_q : acc_q;
  assign q_fix = neg_q ? -acc_q[31:0] : acc_q[31:0];
  assign r_fix = neg_r_q ? -acc_q[63:32] : acc_q[63:32];

  always_comb begin
    state_d = state_q;
    case (state_q)
      mieu_pkg::StIdle:  if (insn.valid && insn.ready) state_d = mieu_pkg::StReadA;
      mieu_pkg::StReadA: state_d = mieu_pkg::StReadB;
      mieu_pkg::StReadB: state_d = mieu_pkg::StExec;
      mieu_pkg::StExec:  state_d = start_md ? mieu_pkg::StIter : mieu_pkg::StIdle;
      mieu_pkg::StIter:  if (cnt_q == 6'd0) state_d = mieu_pkg::StOut;
      mieu_pkg::StOut:   state_d = mieu_pkg::StIdle;
      default:           state_d = mieu_pkg::StIdle;
    endcase
  end

  assign rf_we    = (state_q == mieu_pkg::StExec) && ex_we;
  assign rf_waddr = ex_dst;
  assign rf_wdata = ex_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mieu_pkg::StIdle;
      rf_vld_q  <= 32'd0;
      pc_q      <= 32'd0;
      dpc_q     <= 32'd4;
      start_q   <= 32'd0;
      hi_q      <= 64'd0;
      lo_q      <= 64'd0;
      out_vld_q <= 1'b0;
      cnt_q     <= 6'd0;
    end else begin
      state_q <= state_d;
      if (res.valid && res.ready) out_vld_q <= 1'b0;
      if (cfg_wr) begin
        start_q <= pwdata & mieu_pkg::AddrMask;
        pc_q    <= pwdata & mieu_pkg::AddrMask;
        dpc_q   <= (pwdata & mieu_pkg::AddrMask) + 32'd4;
      end
      if (rf_we) rf_vld_q[ex_dst] <= 1'b1;
      if (state_q == mieu_pkg::StExec) begin
        pc_q  <= dpc_q;
        dpc_q <= next_dpc;
        cnt_q <= 6'd31;
        if (!start_md) out_vld_q <= 1'b1;
      end
      if (state_q == mieu_pkg::StIter) cnt_q <= cnt_q - 6'd1;
      if (state_q == mieu_pkg::StOut) begin
        out_vld_q <= 1'b1;
        if (special_q) begin
          // divide by zero or overflow, results set at start
          hi_q <= hi_q;
        end else if (is_div_q) begin
          lo_q <= sx32(q_fix);
          hi_q <= sx32(r_fix);
        end else begin
          lo_q <= sx32(prod[31:0]);
          hi_q <= sx32(prod[63:32]);
        end
      end
      if (state_q == mieu_pkg::StExec && start_md && md_div) begin
        if (b32 == 32'd0) begin
          lo_q <= (md_signed && a32[31]) ? 64'd1 : '1;
          hi_q <= sx32(a32);
        end else if (md_signed && a32 == mieu_pkg::Sign32 && b32 == '1) begin
          lo_q <= sx32(mieu_pkg::Sign32);
          hi_q <= 64'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (insn.valid && insn.ready) ins_q <= insn.instruction_word;
    if (state_q == mieu_pkg::StReadA)
      a_q <= rf_vld_q[rs] ? rf_rdata_q : 64'd0;
    if (state_q == mieu_pkg::StReadB)
      b_q <= rf_vld_q[rt] ? rf_rdata_q : 64'd0;
    if (state_q == mieu_pkg::StExec) begin
      is_div_q  <= md_div;
      special_q <= md_div && ((b32 == 32'd0) ||
                   (md_signed && a32 == mieu_pkg::Sign32 && b32 == '1));
      neg_q     <= md_signed && (a32[31] ^ b32[31]);
      neg_r_q   <= md_signed && a32[31];
      divs_q    <= md_div ? mb : ma;
      acc_q     <= md_div ? {32'd0, ma} : {32'd0, mb};
      out_q.executed_address   <= pc_q;
      out_q.fetch_address      <= dpc_q;
      out_q.write_valid        <= ex_we;
      out_q.write_register     <= ex_we ? ex_dst : 5'd0;
      out_q.write_value        <= ex_we ? ex_val : 64'd0;
      out_q.overflow_flag      <= ex_ovf;
      out_q.unimplemented_flag <= ex_unimpl;
    end
    if (state_q == mieu_pkg::StIter) acc_q <= acc_step;
  end

  assign res.valid              = out_vld_q;
  assign res.executed_address   = out_q.executed_address;
  assign res.fetch_address      = out_q.fetch_address;
  assign res.write_valid        = out_q.write_valid;
  assign res.write_register     = out_q.write_register;
  assign res.write_value        = out_q.write_value;
  assign res.hi_value           = hi_q;
  assign res.lo_value           = lo_q;
  assign res.overflow_flag      = out_q.overflow_flag;
  assign res.unimplemented_flag = out_q.unimplemented_flag;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mieu_pkg::StIdle) |-> !insn.ready)
    else $error("instruction accepted while busy");
  a_r0_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rf_we && rf_waddr == 5'd0))
    else $error("write to register zero");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !(res.write_valid && (res.overflow_flag || res.unimplemented_flag)))
    else $error("write together with a fault flag");
  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mieu_pkg::StIter && cnt_q == 6'd0) |=> (state_q == mieu_pkg::StOut))
    else $error("iteration did not finish");
`endif

endmodule
